// ===== design/pls_pkg.sv =====
package pls_pkg;

    localparam int DEF_CAPACITY = 16;

    localparam int ITEM_W = 32;
    localparam int POS_W  = 5;
    localparam int CMD_W  = 2;
    localparam int STAT_W = 2;

    localparam int S_TDATA_W = 40;
    localparam int M_TDATA_W = 48;

    localparam logic [CMD_W-1:0] CMD_INSERT   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DELETE   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RETRIEVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_LOCATE   = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
    localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY = 2'd3;

    // Shift controls broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;
        logic del;
    } cell_ctl_t;

endpackage

// ===== design/pls_cell.sv =====
module pls_cell
    import pls_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int CMP_W = 5
) (
    input  logic              aclk,
    input  cell_ctl_t         ctl,
    input  logic [CMP_W-1:0]  pos,
    input  logic [CMP_W-1:0]  count,
    input  logic [ITEM_W-1:0] value,
    input  logic [ITEM_W-1:0] left_data,
    input  logic [ITEM_W-1:0] right_data,
    output logic [ITEM_W-1:0] data,
    output logic              hit,
    output logic              sel
);

    localparam logic [CMP_W:0] IDX  = (CMP_W+1)'(INDEX);
    localparam logic [CMP_W:0] IDX1 = (CMP_W+1)'(INDEX + 1);

    logic [ITEM_W-1:0] data_reg;
    logic [ITEM_W-1:0] data_next;
    logic [CMP_W:0]    pos_x;
    logic [CMP_W:0]    cnt_x;

    assign pos_x = {1'b0, pos};
    assign cnt_x = {1'b0, count};

    always_comb begin
        data_next = data_reg;
        if (ctl.ins) begin
            if (IDX == pos_x) begin
                data_next = value;
            end else if (IDX > pos_x) begin
                data_next = left_data;
            end
        end else if (ctl.del) begin
            // The gap closes from the deleted slot to the end of the row.
            if (IDX1 >= pos_x) begin
                data_next = right_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
    end

    assign data = data_reg;
    assign hit  = (IDX < cnt_x) && (data_reg == value);
    assign sel  = (IDX1 == pos_x);

endmodule

// ===== design/pls_select.sv =====
module pls_select
    import pls_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic [CAPACITY-1:0] hit,
    input  logic [CAPACITY-1:0] sel,
    input  logic [ITEM_W-1:0]   data [CAPACITY],
    output logic [POS_W-1:0]    found,
    output logic [ITEM_W-1:0]   item
);

    always_comb begin
        found = '0;
        item  = '0;
        // Scanning downward leaves the lowest matching position in found.
        for (int i = CAPACITY - 1; i >= 0; i--) begin
            if (hit[i]) begin
                found = POS_W'(i + 1);
            end
        end
        // At most one select bit is set, so an OR of the gated cells is a mux.
        for (int j = 0; j < CAPACITY; j++) begin
            item = item | (data[j] & {ITEM_W{sel[j]}});
        end
    end

endmodule

// ===== design/positional_list_store.sv =====
// Positional list store: an ordered list of up to CAPACITY signed 32-bit items.
// The s_ channel carries one command per transfer (insert, delete, retrieve or
// locate); the m_ channel returns exactly one result transfer per command with
// the item taken, the locate position, the new list length and a status code.
// The items sit in a row of cells; every cell compares and shifts at once, so
// a command completes in the cycle it is accepted. The result appears on m_
// in the cycle after the command transfer, and one command per cycle is
// sustained while the receiver keeps m_tready high. The output register frees
// the input side as soon as its result is taken, in the same cycle.
// When the receiver stalls, the result holds and s_tready drops until the
// pending result has been transferred.
// Reset empties the list and drops m_tvalid; the cell contents are left as
// they are and are never read before they are written again.
// Failed commands (bad position, insert when full, delete or retrieve on an
// empty list) return an error status and leave the list unchanged.
module positional_list_store
    import pls_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    // command[1:0], position[6:2], value[38:7], zero fill [39]
    input  logic [S_TDATA_W-1:0] s_tdata,
    output logic                 m_tvalid,
    input  logic                 m_tready,
    // item_out[31:0], found_position[36:32], list_length[41:37],
    // status[43:42], zero fill [47:44]
    output logic [M_TDATA_W-1:0] m_tdata
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam logic [CMP_W-1:0] CAP_C = CMP_W'(CAPACITY);

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 m_tvalid_reg;
    logic                 m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg;
    logic [M_TDATA_W-1:0] m_tdata_next;

    logic                 accept;
    logic [CMD_W-1:0]     cmd;
    logic [POS_W-1:0]     pos;
    logic [ITEM_W-1:0]    val;
    logic [CMP_W-1:0]     pos_c;
    logic [CMP_W-1:0]     cnt_c;
    logic [CMP_W-1:0]     cnt_after;
    logic [STAT_W-1:0]    status;
    logic [ITEM_W-1:0]    item_out;
    logic [POS_W-1:0]     found_out;
    cell_ctl_t            ctl;

    logic [ITEM_W-1:0]    cell_data [CAPACITY];
    logic [CAPACITY-1:0]  cell_hit;
    logic [CAPACITY-1:0]  cell_sel;
    logic [POS_W-1:0]     sel_found;
    logic [ITEM_W-1:0]    sel_item;

    assign cmd   = s_tdata[CMD_W-1:0];
    assign pos   = s_tdata[CMD_W+POS_W-1:CMD_W];
    assign val   = s_tdata[CMD_W+POS_W+ITEM_W-1:CMD_W+POS_W];
    assign pos_c = CMP_W'(pos);
    assign cnt_c = CMP_W'(count_reg);

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;

    always_comb begin
        status = ST_OK;
        case (cmd)
            CMD_INSERT: begin
                if (pos_c > cnt_c) begin
                    status = ST_RANGE;
                end else if (cnt_c >= CAP_C) begin
                    status = ST_FULL;
                end
            end
            CMD_DELETE, CMD_RETRIEVE: begin
                if (count_reg == '0) begin
                    status = ST_EMPTY;
                end else if (pos == '0 || pos_c > cnt_c) begin
                    status = ST_RANGE;
                end
            end
            default: begin
                status = ST_OK;
            end
        endcase
    end

    always_comb begin
        ctl.ins    = accept && (status == ST_OK) && (cmd == CMD_INSERT);
        ctl.del    = accept && (status == ST_OK) && (cmd == CMD_DELETE);
        count_next = count_reg;
        if (ctl.ins) begin
            count_next = count_reg + CNT_W'(1);
        end else if (ctl.del) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++) begin : g_cell
            logic [ITEM_W-1:0] left_d;
            logic [ITEM_W-1:0] right_d;
            if (g == 0) begin : g_first
                assign left_d = '0;
            end else begin : g_mid
                assign left_d = cell_data[g-1];
            end
            if (g == CAPACITY - 1) begin : g_last
                assign right_d = cell_data[g];
            end else begin : g_body
                assign right_d = cell_data[g+1];
            end
            pls_cell #(
                .INDEX (g),
                .CMP_W (CMP_W)
            ) u_cell (
                .aclk       (aclk),
                .ctl        (ctl),
                .pos        (pos_c),
                .count      (cnt_c),
                .value      (val),
                .left_data  (left_d),
                .right_data (right_d),
                .data       (cell_data[g]),
                .hit        (cell_hit[g]),
                .sel        (cell_sel[g])
            );
        end
    endgenerate

    pls_select #(
        .CAPACITY (CAPACITY)
    ) u_select (
        .hit   (cell_hit),
        .sel   (cell_sel),
        .data  (cell_data),
        .found (sel_found),
        .item  (sel_item)
    );

    always_comb begin
        cnt_after = CMP_W'(count_next);
        item_out  = '0;
        found_out = '0;
        if ((cmd == CMD_DELETE || cmd == CMD_RETRIEVE) && status == ST_OK) begin
            item_out = sel_item;
        end
        if (cmd == CMD_LOCATE) begin
            found_out = sel_found;
        end

        m_tvalid_next = m_tvalid_reg;
        m_tdata_next  = m_tdata_reg;
        if (accept) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = {4'b0, status, cnt_after[POS_W-1:0], found_out, item_out};
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            count_reg    <= count_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

// ===== dv/tb.sv =====
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import pls_pkg::*;

    localparam int CAPACITY      = DEF_CAPACITY;
    localparam int STALL_LIMIT   = 1000;
    localparam int HOLD_START    = 400;
    localparam int HOLD_CYCLES   = 80;
    localparam int RANDOM_ITEMS  = 500;

    typedef struct packed {
        logic [CMD_W-1:0]         cmd;
        logic [POS_W-1:0]         pos;
        logic signed [ITEM_W-1:0] value;
    } list_cmd_t;

    typedef struct packed {
        logic signed [ITEM_W-1:0] item;
        logic [POS_W-1:0]         found;
        logic [POS_W-1:0]         length;
        logic [STAT_W-1:0]        status;
    } list_result_t;

    typedef struct packed {
        logic [CAPACITY-1:0][ITEM_W-1:0] items;
        logic [15:0]                     count;
    } list_state_t;

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_tdata;

    list_cmd_t    pending_cmds[$];
    list_result_t expected_results[$];
    list_state_t  list_shadow;
    list_state_t  plan_shadow;
    list_cmd_t    drv_item;
    list_cmd_t    seen_cmd;
    list_result_t seen_result;
    list_result_t want_result;
    int           mismatch_count = 0;
    int           cycle_no = 0;
    int           stall_cycles = 0;
    int           hold_left = 0;
    logic         hold_done = 1'b0;
    logic         steady_window;

    positional_list_store #(
        .CAPACITY(CAPACITY)
    ) uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    // Applies one command to a list and returns the result it produces.
    function automatic list_result_t apply_command(inout list_state_t st, input list_cmd_t c);
        list_result_t r;
        int i;
        r = '{item: '0, found: '0, length: '0, status: ST_OK};
        case (c.cmd)
            CMD_INSERT: begin
                if (c.pos > st.count) begin
                    r.status = ST_RANGE;
                end else if (st.count >= CAPACITY) begin
                    r.status = ST_FULL;
                end else begin
                    for (i = st.count; i > c.pos; i--) st.items[i] = st.items[i-1];
                    st.items[c.pos] = c.value;
                    st.count = st.count + 1;
                end
            end
            CMD_DELETE, CMD_RETRIEVE: begin
                if (st.count == 0) begin
                    r.status = ST_EMPTY;
                end else if (c.pos == 0 || c.pos > st.count) begin
                    r.status = ST_RANGE;
                end else begin
                    r.item = st.items[c.pos-1];
                    if (c.cmd == CMD_DELETE) begin
                        for (i = c.pos - 1; i + 1 < st.count; i++) st.items[i] = st.items[i+1];
                        st.count = st.count - 1;
                    end
                end
            end
            default: begin
                for (i = 0; i < st.count; i++) begin
                    if (r.found == 0 && st.items[i] == c.value) r.found = POS_W'(i + 1);
                end
            end
        endcase
        r.length = st.count[POS_W-1:0];
        return r;
    endfunction

    task automatic note_mismatch(input string msg);
        $display("mismatch at %0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic add_cmd(input logic [CMD_W-1:0] cmd, input int pos, input logic [31:0] value);
        list_cmd_t c;
        c.cmd = cmd;
        c.pos = POS_W'(pos);
        c.value = value;
        pending_cmds.push_back(c);
        void'(apply_command(plan_shadow, c));
    endtask

    // Mostly a small pool with extremes so that locate finds duplicates.
    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(9);
        if (r < 4) return 32'($urandom_range(3)) - 32'd2;
        if (r == 4) return 32'h7FFF_FFFF;
        if (r == 5) return 32'h8000_0000;
        return $urandom;
    endfunction

    task automatic add_random_cmd(input int phase);
        int roll;
        int len;
        logic [CMD_W-1:0] cmd;
        logic [31:0] value;
        len = plan_shadow.count;
        roll = $urandom_range(99);
        if (roll < 10) begin
            add_cmd(CMD_W'($urandom_range(3)), $urandom_range(31), $urandom);
        end else begin
            roll = $urandom_range(99);
            case (phase)
                0: cmd = roll < 70 ? CMD_INSERT : roll < 80 ? CMD_DELETE :
                         roll < 90 ? CMD_RETRIEVE : CMD_LOCATE;
                1: cmd = roll < 10 ? CMD_INSERT : roll < 70 ? CMD_DELETE :
                         roll < 85 ? CMD_RETRIEVE : CMD_LOCATE;
                default: cmd = CMD_W'(roll / 25);
            endcase
            case (cmd)
                CMD_INSERT: add_cmd(cmd, $urandom_range(len, 0), pick_value());
                CMD_DELETE, CMD_RETRIEVE: begin
                    if (len == 0) add_cmd(cmd, $urandom_range(31), $urandom);
                    else add_cmd(cmd, $urandom_range(len, 1), $urandom);
                end
                default: begin
                    if (len > 0 && $urandom_range(9) < 6)
                        value = plan_shadow.items[$urandom_range(len - 1)];
                    else
                        value = pick_value();
                    add_cmd(cmd, $urandom_range(31), value);
                end
            endcase
        end
    endtask

    assign steady_window = (cycle_no >= 150 && cycle_no < 350);

    always @(posedge aclk) begin
        cycle_no <= cycle_no + 1;
    end

    // Sender: a new item is offered only once the current one has transferred.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (pending_cmds.size() != 0 && (steady_window || $urandom_range(99) >= 6)) begin
                drv_item = pending_cmds.pop_front();
                s_tdata  <= {1'b0, drv_item.value, drv_item.pos, drv_item.cmd};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver: random stalls plus one long hold-off that backs up the input.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (!hold_done && cycle_no == HOLD_START) begin
            hold_done <= 1'b1;
            hold_left <= HOLD_CYCLES;
            m_tready  <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else begin
            m_tready <= steady_window || ($urandom_range(99) >= 6);
        end
    end

    // Results are checked before the command of the same edge is predicted;
    // a result can never belong to a command accepted at the same edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                seen_result.item   = m_tdata[31:0];
                seen_result.found  = m_tdata[36:32];
                seen_result.length = m_tdata[41:37];
                seen_result.status = m_tdata[43:42];
                if (expected_results.size() == 0) begin
                    note_mismatch("result transfer with no command pending");
                end else begin
                    want_result = expected_results.pop_front();
                    if (seen_result.item !== want_result.item)
                        note_mismatch($sformatf("item_out %0d, expected %0d",
                            seen_result.item, want_result.item));
                    if (seen_result.found !== want_result.found)
                        note_mismatch($sformatf("found_position %0d, expected %0d",
                            seen_result.found, want_result.found));
                    if (seen_result.length !== want_result.length)
                        note_mismatch($sformatf("list_length %0d, expected %0d",
                            seen_result.length, want_result.length));
                    if (seen_result.status !== want_result.status)
                        note_mismatch($sformatf("status %0d, expected %0d",
                            seen_result.status, want_result.status));
                end
            end
            if (s_tvalid && s_tready) begin
                seen_cmd.cmd   = s_tdata[1:0];
                seen_cmd.pos   = s_tdata[6:2];
                seen_cmd.value = s_tdata[38:7];
                expected_results.push_back(apply_command(list_shadow, seen_cmd));
            end
        end
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) stall_cycles <= 0;
            else stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT) begin
                $display("TB_ERROR");
                $finish;
            end
        end
    end

    initial begin
        list_shadow = '0;
        plan_shadow = '0;

        // Commands on an empty list.
        add_cmd(CMD_DELETE, 1, 0);
        add_cmd(CMD_RETRIEVE, 0, 0);
        add_cmd(CMD_LOCATE, 0, 0);
        add_cmd(CMD_INSERT, 1, 5);
        // Front, after-first and middle inserts with extreme values.
        add_cmd(CMD_INSERT, 0, 32'h7FFF_FFFF);
        add_cmd(CMD_INSERT, 1, 32'h8000_0000);
        add_cmd(CMD_INSERT, 0, 0);
        add_cmd(CMD_INSERT, 31, 32'hFFFF_FFFF);
        add_cmd(CMD_INSERT, 2, 32'hFFFF_FFFF);
        // Bad and good retrieve positions, locate hit and miss.
        add_cmd(CMD_RETRIEVE, 0, 0);
        add_cmd(CMD_RETRIEVE, 5, 0);
        add_cmd(CMD_RETRIEVE, 4, 0);
        add_cmd(CMD_LOCATE, 0, 32'h8000_0000);
        add_cmd(CMD_LOCATE, 31, 12345);
        // Duplicate at the end; locate must report the first copy.
        add_cmd(CMD_INSERT, 4, 32'h7FFF_FFFF);
        add_cmd(CMD_LOCATE, 0, 32'h7FFF_FFFF);
        add_cmd(CMD_DELETE, 31, 0);
        add_cmd(CMD_DELETE, 0, 0);
        add_cmd(CMD_DELETE, 2, 0);
        add_cmd(CMD_DELETE, 4, 0);
        add_cmd(CMD_DELETE, 1, 0);
        add_cmd(CMD_RETRIEVE, 16, 0);

        // Alternating fill, drain and mixed phases reach both full and empty.
        for (int n = 0; n < RANDOM_ITEMS; n++) add_random_cmd((n / 40) % 3);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (pending_cmds.size() != 0 || s_tvalid || expected_results.size() != 0)
            @(posedge aclk);
        repeat (10) @(posedge aclk);

        if (mismatch_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
